[src/framed_packet_receiver_assert.svh]
// assertion macros for the framed packet receiver
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framed_packet_receiver: implication check failed");

// next-cycle implication, checked outside reset
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framed_packet_receiver: next-cycle check failed");

`endif

[src/fpr_pkg.sv]
// types and constants of the framed packet receiver
`timescale 1ns / 1ps

package fpr_pkg;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_PAYLOAD  = 3'd2;
    localparam logic [2:0] ST_GOOD     = 3'd3;
    localparam logic [2:0] ST_LEN_ERR  = 3'd4;
    localparam logic [2:0] ST_TAIL_ERR = 3'd5;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 8'd1;

    localparam logic [7:0] HEAD_BYTE_RST = 8'hA5;
    localparam logic [7:0] TAIL_BYTE_RST = 8'hFC;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_offset;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic        restarted;
    } t_result;

endpackage

[src/framed_packet_receiver.sv]
// framed packet receiver: deframes head, type, length, payload and tail bytes
// input channel: i_in_valid / o_in_stall carry one received byte per transfer
// output channel: o_out_valid / i_out_stall carry one result per input byte
// every result gives a status (ignored, header, payload, good, length error,
// tail error), the payload byte and its offset, the frame type and length,
// and a flag for a frame abandoned by a new head byte
// config channel: i_cfg_valid / o_cfg_ready with an index and data, index 0
// sets the head byte and index 1 the tail byte; o_cfg_ready is always high
// a result is registered; throughput: one byte per cycle while o_in_stall
// is low, set by the single registered frame update
// a two-entry output stage (result register plus skid register) lets a byte
// transfer in while a finished result waits; o_in_stall rises only when both
// entries hold results, and falls the cycle after the receiver takes one
// reset: synchronous active low, clears the frame state, empties the output
// stage and loads head 0xa5, tail 0xfc
`timescale 1ns / 1ps

module framed_packet_receiver #(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_byte_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_payload_byte,
    output logic [9:0]                     o_payload_offset,
    output logic [7:0]                     o_frame_type,
    output logic [15:0]                    o_frame_length,
    output logic                           o_restarted,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import fpr_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_EXT = 17'(MAX_PAYLOAD);
    localparam logic [15:0] LEN_RST = 16'(MAX_PAYLOAD);

    logic [7:0]       r_head;
    logic [7:0]       r_tail;
    logic             r_in_frame;
    logic [POS_W-1:0] r_position;
    logic [7:0]       r_cur_type;
    logic [7:0]       r_length_low;
    logic [15:0]      r_cur_length;

    logic             n_in_frame;
    logic [POS_W-1:0] n_position;
    logic [7:0]       n_cur_type;
    logic [7:0]       n_length_low;
    logic [15:0]      n_cur_length;
    t_result          n_result;

    t_result          r_out;
    logic             r_out_valid;
    t_result          r_skid;
    logic             r_skid_valid;

    logic             in_xfer;
    logic             out_xfer;
    logic             cfg_xfer;

    logic             is_head;
    logic             frame_open;
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      len_eff;
    logic [16:0]      pos_ext;
    logic [16:0]      len_p4;
    logic             tail_beyond;
    logic [16:0]      limit;
    logic [15:0]      new_length;
    logic [16:0]      pos_m4;

    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign out_xfer    = r_out_valid & ~i_out_stall;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= HEAD_BYTE_RST;
            r_tail <= TAIL_BYTE_RST;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_HEAD_BYTE: r_head <= i_cfg_data;
                CFG_TAIL_BYTE: r_tail <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame decode for one byte
    always_comb begin
        is_head     = (i_byte_in == r_head);
        frame_open  = is_head | r_in_frame;
        pos_eff     = is_head ? '0 : r_position;
        len_eff     = is_head ? LEN_RST : r_cur_length;
        pos_ext     = 17'(pos_eff);
        len_p4      = {1'b0, len_eff} + 17'd4;
        tail_beyond = (len_p4 > MAX_EXT);
        limit       = tail_beyond ? MAX_EXT : len_p4;
        new_length  = {i_byte_in, r_length_low};
        pos_m4      = pos_ext - 17'd4;

        n_in_frame   = frame_open;
        n_position   = pos_eff;
        n_cur_type   = r_cur_type;
        n_length_low = r_length_low;
        n_cur_length = len_eff;

        n_result                = '0;
        n_result.status         = ST_IGNORED;
        n_result.restarted      = is_head & r_in_frame;

        if (frame_open) begin
            if (pos_eff == POS_W'(0)) begin
                n_result.status = ST_HEADER;
                n_position      = POS_W'(1);
            end else if (pos_eff == POS_W'(1)) begin
                n_cur_type      = i_byte_in;
                n_result.status = ST_HEADER;
                n_position      = POS_W'(2);
            end else if (pos_eff == POS_W'(2)) begin
                n_length_low    = i_byte_in;
                n_result.status = ST_HEADER;
                n_position      = POS_W'(3);
            end else if (pos_eff == POS_W'(3)) begin
                n_cur_length = new_length;
                if ({1'b0, new_length} > MAX_EXT) begin
                    n_result.status       = ST_LEN_ERR;
                    n_result.frame_type   = r_cur_type;
                    n_result.frame_length = new_length;
                    n_in_frame            = 1'b0;
                    n_position            = '0;
                end else begin
                    n_result.status = ST_HEADER;
                    n_position      = POS_W'(4);
                end
            end else if (pos_ext >= limit) begin
                n_result.status       = (!tail_beyond && i_byte_in == r_tail) ?
                                        ST_GOOD : ST_TAIL_ERR;
                n_result.frame_type   = r_cur_type;
                n_result.frame_length = len_eff;
                n_in_frame            = 1'b0;
                n_position            = '0;
            end else begin
                n_result.status         = ST_PAYLOAD;
                n_result.payload_byte   = i_byte_in;
                n_result.payload_offset = pos_m4[9:0];
                n_result.frame_type     = r_cur_type;
                n_result.frame_length   = len_eff;
                n_position              = pos_eff + POS_W'(1);
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_position   <= '0;
            r_cur_type   <= '0;
            r_length_low <= '0;
            r_cur_length <= LEN_RST;
        end else if (in_xfer) begin
            r_in_frame   <= n_in_frame;
            r_position   <= n_position;
            r_cur_type   <= n_cur_type;
            r_length_low <= n_length_low;
            r_cur_length <= n_cur_length;
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid && out_xfer) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && out_xfer) begin
            r_out <= r_skid;
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_offset = r_out.payload_offset;
    assign o_frame_type     = r_out.frame_type;
    assign o_frame_length   = r_out.frame_length;
    assign o_restarted      = r_out.restarted;

`include "framed_packet_receiver_assert.svh"

    `FPR_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `FPR_ASSERT_IMPLY(a_idle_pos_zero, i_clk, i_rst_n, !r_in_frame, r_position == '0)
    `FPR_ASSERT_IMPLY(a_len_in_range, i_clk, i_rst_n,
        r_in_frame && r_position >= POS_W'(4), 17'(r_cur_length) <= MAX_EXT)
    `FPR_ASSERT_NEXT(a_fill_skid, i_clk, i_rst_n,
        in_xfer && r_out_valid && i_out_stall, r_skid_valid)

endmodule

[tb/sv/framed_packet_receiver_tb.sv]
// self-checking testbench for the framed packet receiver with a frame scoreboard
`timescale 1ns / 1ps

module framed_packet_receiver_tb;
    import fpr_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    class frame_scoreboard;
        logic [7:0]  head_val;
        logic [7:0]  tail_val;
        bit          in_frame;
        int unsigned pos;
        logic [7:0]  ftype;
        logic [7:0]  len_lo;
        logic [15:0] flen;
        t_result     pending[$];
        int unsigned errors;

        function new();
            head_val = HEAD_BYTE_RST;
            tail_val = TAIL_BYTE_RST;
            in_frame = 1'b0;
            pos = 0;
            ftype = '0;
            len_lo = '0;
            flen = 16'(MAX_PAYLOAD);
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_HEAD_BYTE) begin
                head_val = data;
            end else if (idx == CFG_TAIL_BYTE) begin
                tail_val = data;
            end
        endfunction

        // predicts the result of one byte transfer and queues it
        function logic [2:0] note_byte(logic [7:0] b);
            t_result     r;
            bit          show;
            int unsigned lim;
            r = '0;
            show = 1'b0;
            if (b == head_val) begin
                r.restarted = in_frame;
                in_frame = 1'b1;
                pos = 0;
                flen = 16'(MAX_PAYLOAD);
            end
            if (in_frame) begin
                lim = flen + 4;
                if (lim > MAX_PAYLOAD) begin
                    lim = MAX_PAYLOAD;
                end
                if (pos == 0) begin
                    r.status = ST_HEADER;
                    pos = 1;
                end else if (pos == 1) begin
                    ftype = b;
                    r.status = ST_HEADER;
                    pos = 2;
                end else if (pos == 2) begin
                    len_lo = b;
                    r.status = ST_HEADER;
                    pos = 3;
                end else if (pos == 3) begin
                    flen = {b, len_lo};
                    if (flen > MAX_PAYLOAD) begin
                        r.status = ST_LEN_ERR;
                        show = 1'b1;
                        in_frame = 1'b0;
                        pos = 0;
                    end else begin
                        r.status = ST_HEADER;
                        pos = 4;
                    end
                end else if (pos >= lim) begin
                    show = 1'b1;
                    if (flen + 4 <= MAX_PAYLOAD && b == tail_val) begin
                        r.status = ST_GOOD;
                    end else begin
                        r.status = ST_TAIL_ERR;
                    end
                    in_frame = 1'b0;
                    pos = 0;
                end else begin
                    r.status = ST_PAYLOAD;
                    show = 1'b1;
                    r.payload_byte = b;
                    r.payload_offset = 10'(pos - 4);
                    pos = pos + 1;
                end
            end
            if (show) begin
                r.frame_type = ftype;
                r.frame_length = flen;
            end
            pending.push_back(r);
            return r.status;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result with no byte transfer pending: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("restarted", want.restarted, got.restarted);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_byte_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_status;
    logic [7:0]           o_payload_byte;
    logic [9:0]           o_payload_offset;
    logic [7:0]           o_frame_type;
    logic [15:0]          o_frame_length;
    logic                 o_restarted;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    frame_scoreboard sb;
    int unsigned     item_count;
    int unsigned     cycle_count = 0;
    bit              tx_gaps = 1'b1;
    bit              rx_stalls = 1'b1;
    bit              hold_req = 1'b0;
    logic [7:0]      opening_bytes[$];

    framed_packet_receiver #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_byte_in(i_byte_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_payload_byte(o_payload_byte),
        .o_payload_offset(o_payload_offset),
        .o_frame_type(o_frame_type),
        .o_frame_length(o_frame_length),
        .o_restarted(o_restarted),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!tx_gaps || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end
        if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] other_byte(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        do begin
            v = 8'($urandom);
        end while (v == a || v == b);
        return v;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        void'(sb.note_byte(b));
        item_count++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_byte_in <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.set_register(idx, data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned phase);
        logic [7:0] h;
        logic [7:0] t;
        case (phase)
            0: begin
                h = 8'h00;
                t = 8'hFF;
            end
            1: begin
                h = 8'hFF;
                t = 8'h01;
            end
            default: begin
                h = 8'($urandom);
                t = other_byte(h, 8'h00);
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), 8'($urandom));
        end
        write_reg(CFG_HEAD_BYTE, h);
        write_reg(CFG_TAIL_BYTE, t);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(int unsigned len, bit good_tail);
        logic [15:0] lv;
        lv = 16'(len);
        send_byte(sb.head_val);
        send_byte(other_byte(sb.head_val, sb.head_val));
        send_byte(lv[7:0]);
        send_byte(lv[15:8]);
        repeat (len) send_byte(other_byte(sb.head_val, sb.head_val));
        if (good_tail) begin
            send_byte(sb.tail_val);
        end else begin
            send_byte(other_byte(sb.head_val, sb.tail_val));
        end
    endtask

    task automatic random_frame();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(17, 200);
            end else begin
                len = $urandom_range(0, 16);
            end
            send_frame(len, $urandom_range(0, 6) != 0);
        end else if (kind < 80) begin
            len = $urandom_range(MAX_PAYLOAD + 1, 65535);
            send_byte(sb.head_val);
            send_byte(8'($urandom));
            send_byte(len[7:0]);
            send_byte(len[15:8]);
        end else if (kind < 90) begin
            // frame cut short, the next head byte abandons it
            send_byte(sb.head_val);
            repeat ($urandom_range(0, 7)) send_byte(other_byte(sb.head_val, sb.head_val));
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        t_result     seen;
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen = {o_status, o_payload_byte, o_payload_offset, o_frame_type,
                        o_frame_length, o_restarted};
                sb.check_result(seen);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (rx_stalls && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_stall();
                end
            end
        end
    end

    initial begin
        int unsigned phase;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_byte_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored byte, good frame, empty frame, restart, bad tail, length too big
        opening_bytes = '{8'h00,
                          8'hA5, 8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFC,
                          8'hA5, 8'h00, 8'h00, 8'h00, 8'hFC,
                          8'hA5, 8'h12, 8'h01,
                          8'hA5, 8'h7E, 8'h01, 8'h00, 8'h55, 8'h00,
                          8'hA5, 8'h01, 8'h01, 8'h04};
        foreach (opening_bytes[k]) begin
            send_byte(opening_bytes[k]);
        end

        item_count = 0;
        phase = 0;
        while (item_count < ITEM_TARGET) begin
            drain();
            configure(phase);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                hold_req = 1'b1;
                tx_gaps = 1'b0;
                send_frame(40, 1'b1);
                tx_gaps = 1'b1;
                // full-size payload closing at the limit, or a tail past the limit
                if ($urandom_range(0, 1) == 0) begin
                    send_frame(MAX_PAYLOAD - 4, 1'b1);
                end else begin
                    send_frame($urandom_range(MAX_PAYLOAD - 3, MAX_PAYLOAD), 1'b1);
                end
            end
            repeat ((phase == 0) ? 5 : $urandom_range(8, 20)) random_frame();
            phase++;
        end
        drain();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
